FILE: hdl/cms_pkg.sv
// Package with the constants, codes, state types and hash helpers of the count-min sketch.
package cms_pkg;

  localparam int unsigned ROWS_DEF    = 4;
  localparam int unsigned COLUMNS_DEF = 1024;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] ROW_BASE  = 64'ha5a5a5a55a5a5a5a;
  localparam logic [63:0] ROW_STEP  = 64'h9e3779b97f4a7c15;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_MOD,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_UPDATE
  } back_state_e;

  // The FNV prime is 2^40 + 0x1b3, so the product is a shift plus a narrow multiply.
  function automatic logic [63:0] fnv_step(input logic [63:0] acc, input logic [7:0] b);
    logic [63:0] x;
    x = acc ^ {56'd0, b};
    return (x << 40) + (x * 64'h1b3);
  endfunction

  // Hash state after the eight seed bytes of a row; called with constant rows only.
  function automatic logic [63:0] seed_hash(input int unsigned row);
    logic [63:0] s;
    logic [63:0] a;
    s = ROW_BASE ^ (64'(row) * ROW_STEP);
    a = FNV_BASIS;
    for (int i = 0; i < 8; i++) begin
      a = fnv_step(a, s[8*i +: 8]);
    end
    return a;
  endfunction

endpackage

FILE: hdl/count_min_sketch_unit.sv
// Top level of the count-min sketch: front end, queue and back end.
//
// Channel   Direction  Handshake                 Fields
// command   in         start_i high, busy_o low  cmd_i, key_hash_i, add_amount_i
// result    out        valid_o strobe, 1 cycle   estimate_o, total_count_o
//
// A command passes the front end in order: the accept, 8 hash byte steps for all rows at
// once, 16 remainder steps of 4 bits, one queue transfer; a new command is taken only after
// the last one is in the queue. The back end reads the RAMs on the pop and writes them in
// B_UPDATE before it pops again; a query result is registered from the RAM read data. An add
// of zero is dropped at once. After reset a clearing pass zeroes every column of the
// counters; busy_o is high then. The receiver cannot stall; results are never held back.
module count_min_sketch_unit #(
  parameter int unsigned ROWS    = cms_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS = cms_pkg::COLUMNS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  cms_pkg::cmd_e cmd_i,
  input  logic [63:0]   key_hash_i,
  input  logic [31:0]   add_amount_i,
  output logic          valid_o,
  output logic [31:0]   estimate_o,
  output logic [63:0]   total_count_o
);
  import cms_pkg::*;

  localparam int unsigned CW = $clog2(COLUMNS);
  localparam int unsigned QW = 1 + 32 + ROWS * CW;

  logic              push, pop, full, empty, clearing, full_seen;
  cmd_e              f_cmd, h_cmd;
  logic [31:0]       f_amount, h_amount;
  logic [ROWS*CW-1:0] f_slots, h_slots;
  logic [QW-1:0]     qin, qout;

  cms_front #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .hold_i          (clearing),
    .cmd_i           (cmd_i),
    .key_hash_i      (key_hash_i),
    .add_amount_i    (add_amount_i),
    .busy_o          (busy_o),
    .push_o          (push),
    .full_i_unused_o (full_seen),
    .full_i          (full),
    .q_cmd_o         (f_cmd),
    .q_amount_o      (f_amount),
    .q_slots_o       (f_slots)
  );

  assign qin = {f_cmd, f_amount, f_slots};

  cms_fifo #(.W(QW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (qin),
    .pop_i   (pop),
    .rdata_o (qout),
    .full_o  (full),
    .empty_o (empty)
  );

  assign h_cmd    = cmd_e'(qout[QW-1]);
  assign h_amount = qout[QW-2 -: 32];
  assign h_slots  = qout[ROWS*CW-1:0];

  cms_back #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .h_cmd_i       (h_cmd),
    .h_amount_i    (h_amount),
    .h_slots_i     (h_slots),
    .pop_o         (pop),
    .clearing_o    (clearing),
    .valid_o       (valid_o),
    .estimate_o    (estimate_o),
    .total_count_o (total_count_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full_seen)) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && empty)) else $error("queue read while empty");

  a_result_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("results in adjacent cycles");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> (!pop && !valid_o)) else $error("activity during clearing pass");

endmodule

FILE: hdl/cms_ram.sv
// Generic single-port RAM with registered read data.
module cms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: hdl/cms_fifo.sv
// Two-entry queue between the hashing front end and the counter back end.
module cms_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         full_o,
  output logic         empty_o
);

  logic [W-1:0] mem_q [2];
  logic         wptr_q, wptr_d;
  logic         rptr_q, rptr_d;
  logic [1:0]   cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q ^ push_i;
    rptr_d = rptr_q ^ pop_i;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rptr_q];
  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);

endmodule

FILE: hdl/cms_front.sv
// Front end: takes commands, drops empty adds, hashes the key and reduces each row's slot.
module cms_front #(
  parameter int unsigned ROWS    = cms_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS = cms_pkg::COLUMNS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               hold_i,
  input  cms_pkg::cmd_e                      cmd_i,
  input  logic [63:0]                        key_hash_i,
  input  logic [31:0]                        add_amount_i,
  output logic                               busy_o,
  output logic                               push_o,
  output logic                               full_i_unused_o,
  input  logic                               full_i,
  output cms_pkg::cmd_e                      q_cmd_o,
  output logic [31:0]                        q_amount_o,
  output logic [ROWS*$clog2(COLUMNS)-1:0]    q_slots_o
);
  import cms_pkg::*;

  localparam int unsigned CW = $clog2(COLUMNS);
  localparam int unsigned RW = CW + 1;

  front_state_e state_q, state_d;
  logic [3:0]   cnt_q, cnt_d;
  logic [63:0]  key_q;
  cmd_e         cmd_q;
  logic [31:0]  amount_q;
  logic [63:0]  acc_q [ROWS];
  logic [RW-1:0] rem_q [ROWS];
  logic         take;

  function automatic logic [RW-1:0] mod_nibble(input logic [RW-1:0] r, input logic [3:0] nib);
    logic [RW-1:0] t;
    t = r;
    for (int i = 3; i >= 0; i--) begin
      t = {t[CW-1:0], nib[i]};
      if (t >= RW'(COLUMNS)) begin
        t = t - RW'(COLUMNS);
      end
    end
    return t;
  endfunction

  assign take = (state_q == F_IDLE) && start_i && !hold_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      F_IDLE: begin
        cnt_d = 4'd0;
        if (take && !(cmd_i == CMD_ADD && add_amount_i == 32'd0)) begin
          state_d = F_HASH;
        end
      end
      F_HASH: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd7) begin
          state_d = F_MOD;
          cnt_d   = 4'd0;
        end
      end
      F_MOD: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    busy_o = (state_q != F_IDLE) || hold_i;
    push_o = (state_q == F_PUSH) && !full_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= 4'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      key_q    <= key_hash_i;
      cmd_q    <= cmd_i;
      amount_q <= add_amount_i;
    end else if (state_q == F_HASH) begin
      key_q <= key_q >> 8;
    end
  end

  for (genvar r = 0; r < ROWS; r++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (take) begin
        acc_q[r] <= seed_hash(r);
        rem_q[r] <= '0;
      end else if (state_q == F_HASH) begin
        acc_q[r] <= fnv_step(acc_q[r], key_q[7:0]);
      end else if (state_q == F_MOD) begin
        rem_q[r] <= mod_nibble(rem_q[r], acc_q[r][63:60]);
        acc_q[r] <= acc_q[r] << 4;
      end
    end
    assign q_slots_o[r*CW +: CW] = rem_q[r][CW-1:0];
  end

  assign q_cmd_o         = cmd_q;
  assign q_amount_o      = amount_q;
  assign full_i_unused_o = full_i;

endmodule

FILE: hdl/cms_back.sv
// Back end: clears the counter RAMs, then runs read-modify-write adds and minimum queries.
module cms_back #(
  parameter int unsigned ROWS    = cms_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS = cms_pkg::COLUMNS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            empty_i,
  input  cms_pkg::cmd_e                   h_cmd_i,
  input  logic [31:0]                     h_amount_i,
  input  logic [ROWS*$clog2(COLUMNS)-1:0] h_slots_i,
  output logic                            pop_o,
  output logic                            clearing_o,
  output logic                            valid_o,
  output logic [31:0]                     estimate_o,
  output logic [63:0]                     total_count_o
);
  import cms_pkg::*;

  localparam int unsigned CW = $clog2(COLUMNS);

  back_state_e state_q, state_d;
  logic [CW-1:0] clr_q, clr_d;
  cmd_e          cmd_q;
  logic [31:0]   amount_q;
  logic [ROWS*CW-1:0] slots_q;
  logic [63:0]   total_q, total_d;
  logic          valid_q, valid_d;
  logic [31:0]   est_q;
  logic [31:0]   rdata [ROWS];
  logic [31:0]   wdata [ROWS];
  logic [31:0]   min_v;
  logic [64:0]   tsum;
  logic          we;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      B_CLEAR: begin
        clr_d = clr_q + CW'(1);
        if (clr_q == CW'(COLUMNS - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty_i) begin
          state_d = B_UPDATE;
        end
      end
      B_UPDATE: state_d = B_IDLE;
      default:  state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o      = (state_q == B_IDLE) && !empty_i;
    clearing_o = (state_q == B_CLEAR);
    we         = (state_q == B_CLEAR) || ((state_q == B_UPDATE) && (cmd_q == CMD_ADD));
    valid_d    = (state_q == B_UPDATE) && (cmd_q == CMD_QUERY);
    tsum       = {1'b0, total_q} + {33'd0, amount_q};
    total_d    = total_q;
    if ((state_q == B_UPDATE) && (cmd_q == CMD_ADD)) begin
      total_d = tsum[64] ? '1 : tsum[63:0];
    end
    min_v = '1;
    for (int r = 0; r < ROWS; r++) begin
      if (rdata[r] < min_v) begin
        min_v = rdata[r];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      clr_q   <= '0;
      total_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      total_q <= total_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q    <= h_cmd_i;
      amount_q <= h_amount_i;
      slots_q  <= h_slots_i;
    end
    if (valid_d) begin
      est_q <= (min_v == '1) ? 32'd0 : min_v;
    end
  end

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    logic [CW-1:0] addr;
    logic [32:0]   sum;
    always_comb begin
      sum = {1'b0, rdata[r]} + {1'b0, amount_q};
      if (state_q == B_CLEAR) begin
        addr     = clr_q;
        wdata[r] = '0;
      end else if (state_q == B_UPDATE) begin
        addr     = slots_q[r*CW +: CW];
        wdata[r] = sum[32] ? '1 : sum[31:0];
      end else begin
        addr     = h_slots_i[r*CW +: CW];
        wdata[r] = '0;
      end
    end
    cms_ram #(.WIDTH(32), .DEPTH(COLUMNS)) u_ram (
      .clk_i   (clk_i),
      .addr_i  (addr),
      .we_i    (we),
      .wdata_i (wdata[r]),
      .rdata_o (rdata[r])
    );
  end

  assign valid_o       = valid_q;
  assign estimate_o    = est_q;
  assign total_count_o = total_q;

endmodule
